// ===== hdl/pfa_pkg.sv =====
// Package: constants, codes and types shared by the page frame allocator.
package pfa_pkg;

    localparam int NUM_FRAMES = 32;
    localparam int VPN_BITS   = 16;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int FREE_W     = $clog2(NUM_FRAMES + 1);
    localparam int TIME_W     = 32;
    localparam int OWNER_W    = 8;

    localparam logic [OWNER_W-1:0] OWNER_NONE = '1;
    localparam logic [TIME_W-1:0]  CLOCK_MAX  = '1;

    localparam logic [2:0] MODE_ALLOC  = 3'd0;
    localparam logic [2:0] MODE_FORCED = 3'd1;
    localparam logic [2:0] MODE_TOUCH  = 3'd2;
    localparam logic [2:0] MODE_FREE   = 3'd3;
    localparam logic [2:0] MODE_TEST   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic                active;
        logic                have;
        logic [IDX_W-1:0]    best_idx;
        logic [TIME_W-1:0]   best_time;
        logic [OWNER_W-1:0]  v_owner;
        logic [VPN_BITS-1:0] v_vpn;
        logic                v_alloc;
        logic                found;
        logic [IDX_W-1:0]    free_idx;
    } t_token;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic                set_alloc;
        logic                clr_alloc;
        logic                wr_info;
        logic [OWNER_W-1:0]  owner;
        logic [VPN_BITS-1:0] vpn;
        logic                wr_time;
        logic [TIME_W-1:0]   stamp;
    } t_cell_wr;

    typedef struct packed {
        logic [4:0]  result_frame;
        logic        ok;
        logic        is_allocated;
        logic [5:0]  free_count;
        logic [7:0]  victim_owner;
        logic [15:0] victim_vpn;
    } t_result;

endpackage

// ===== hdl/pfa_in_if.sv =====
// Interface: request item channel of the page frame allocator.
interface pfa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  frame;
    logic [7:0]  owner;
    logic [15:0] vpn;

    modport source (output valid, mode, frame, owner, vpn, input ready);
    modport sink (input valid, mode, frame, owner, vpn, output ready);
endinterface

// ===== hdl/pfa_out_if.sv =====
// Interface: result item channel of the page frame allocator.
interface pfa_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  result_frame;
    logic        ok;
    logic        is_allocated;
    logic [5:0]  free_count;
    logic [7:0]  victim_owner;
    logic [15:0] victim_vpn;

    modport source (output valid, result_frame, ok, is_allocated, free_count,
                    victim_owner, victim_vpn, input ready);
    modport sink (input valid, result_frame, ok, is_allocated, free_count,
                  victim_owner, victim_vpn, output ready);
endinterface

// ===== hdl/pfa_cell.sv =====
// Frame cell: one frame's state and one stage of the search token chain.
module pfa_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pfa_pkg::IDX_W-1:0]    i_idx,
    input  pfa_pkg::t_token              i_tok,
    input  pfa_pkg::t_cell_wr            i_wr,
    output pfa_pkg::t_token              o_tok,
    output logic                         o_alloc
);

    logic                           r_alloc;
    logic [pfa_pkg::OWNER_W-1:0]    r_owner;
    logic [pfa_pkg::VPN_BITS-1:0]   r_vpn;
    logic [pfa_pkg::TIME_W-1:0]     r_time;
    pfa_pkg::t_token                r_tok;
    pfa_pkg::t_token                n_tok;
    logic                           take;

    always_comb begin
        n_tok = i_tok;
        take  = i_tok.active && (!i_tok.have || (r_time < i_tok.best_time));
        if (take) begin
            n_tok.have      = 1'b1;
            n_tok.best_idx  = i_idx;
            n_tok.best_time = r_time;
            n_tok.v_owner   = r_owner;
            n_tok.v_vpn     = r_vpn;
            n_tok.v_alloc   = r_alloc;
        end
        if (i_tok.active && !i_tok.found && !r_alloc) begin
            n_tok.found    = 1'b1;
            n_tok.free_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= 1'b0;
            r_owner <= pfa_pkg::OWNER_NONE;
            r_vpn   <= '0;
            r_time  <= '0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && (i_wr.idx == i_idx)) begin
                if (i_wr.set_alloc) begin
                    r_alloc <= 1'b1;
                end
                if (i_wr.clr_alloc) begin
                    r_alloc <= 1'b0;
                end
                if (i_wr.wr_info) begin
                    r_owner <= i_wr.owner;
                    r_vpn   <= i_wr.vpn;
                end
                if (i_wr.wr_time) begin
                    r_time <= i_wr.stamp;
                end
            end
        end
    end

    assign o_tok   = r_tok;
    assign o_alloc = r_alloc;

    a_tok_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.active |=> (r_tok.active && r_tok.have))
        else $error("token lost in cell");
    a_no_write_on_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.active |-> !i_wr.en)
        else $error("cell written during search");
    a_found_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.active && i_tok.found) |=> r_tok.found)
        else $error("free frame mark dropped");

endmodule

// ===== hdl/page_frame_allocator_lru.sv =====
// Top level: page frame allocator with lowest-free and least-recently-used selection.
//
// Requests enter on i_in (mode, frame, owner, vpn) with a valid/ready handshake;
// each request gives exactly one result item on o_out.
// Touch, free, test and unknown modes accept the request and update the frame,
// then present the result.
// Alloc and forced alloc send a search token down the row of 32 frame cells,
// one cell per cycle, then commit the chosen frame and present the result;
// the time to the result and to the next request is set by the length of the
// cell chain.
// One request is in flight at a time; i_in.ready is high only while idle.
// A result holds on o_out until taken; while the receiver stalls no new
// request is accepted.
// Synchronous active-low reset frees all frames, sets owners to none, clears
// pages, access times and the timestamp, and sets the free count to the
// number of frames. The block is ready in the cycle after reset.
module page_frame_allocator_lru (
    input  logic i_clk,
    input  logic i_rst_n,
    pfa_in_if.sink    i_in,
    pfa_out_if.source o_out
);

    pfa_pkg::t_state                 r_state, n_state;
    logic [2:0]                      r_mode, n_mode;
    logic [pfa_pkg::OWNER_W-1:0]     r_owner, n_owner;
    logic [pfa_pkg::VPN_BITS-1:0]    r_vpn, n_vpn;
    logic [pfa_pkg::TIME_W-1:0]      r_stamp, n_stamp;
    logic [pfa_pkg::FREE_W-1:0]      r_free, n_free;
    pfa_pkg::t_result                r_res, n_res;
    pfa_pkg::t_token                 r_launch, n_launch;
    pfa_pkg::t_cell_wr               wr;
    pfa_pkg::t_token                 tok [pfa_pkg::NUM_FRAMES+1];
    logic [pfa_pkg::NUM_FRAMES-1:0]  alloc_vec;
    pfa_pkg::t_token                 tok_end;
    logic                            in_range;

    assign tok[0]  = r_launch;
    assign tok_end = tok[pfa_pkg::NUM_FRAMES];

    for (genvar g = 0; g < pfa_pkg::NUM_FRAMES; g++) begin : g_cell
        pfa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (pfa_pkg::IDX_W'(g)),
            .i_tok   (tok[g]),
            .i_wr    (wr),
            .o_tok   (tok[g+1]),
            .o_alloc (alloc_vec[g])
        );
    end

    assign in_range = 32'(i_in.frame) < 32'(pfa_pkg::NUM_FRAMES);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_owner  = r_owner;
        n_vpn    = r_vpn;
        n_stamp  = r_stamp;
        n_free   = r_free;
        n_res    = r_res;
        n_launch = '0;
        wr       = '0;
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            pfa_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_mode  = i_in.mode;
                    n_owner = i_in.owner;
                    n_vpn   = pfa_pkg::VPN_BITS'(i_in.vpn);
                    n_res   = '0;
                    n_res.victim_owner = pfa_pkg::OWNER_NONE;
                    n_state = pfa_pkg::ST_RESULT;
                    unique case (i_in.mode)
                        pfa_pkg::MODE_ALLOC, pfa_pkg::MODE_FORCED: begin
                            n_launch.active = 1'b1;
                            n_state = pfa_pkg::ST_SCAN;
                        end
                        pfa_pkg::MODE_TOUCH: begin
                            if (in_range) begin
                                if (r_stamp != pfa_pkg::CLOCK_MAX) begin
                                    n_stamp = r_stamp + 1'b1;
                                end
                                wr.en      = 1'b1;
                                wr.idx     = pfa_pkg::IDX_W'(i_in.frame);
                                wr.wr_time = 1'b1;
                                wr.stamp   = n_stamp;
                                n_res.ok   = 1'b1;
                            end
                        end
                        pfa_pkg::MODE_FREE: begin
                            if (in_range) begin
                                if (alloc_vec[pfa_pkg::IDX_W'(i_in.frame)]) begin
                                    n_free = r_free + 1'b1;
                                end
                                wr.en        = 1'b1;
                                wr.idx       = pfa_pkg::IDX_W'(i_in.frame);
                                wr.clr_alloc = 1'b1;
                                n_res.ok     = 1'b1;
                            end
                        end
                        pfa_pkg::MODE_TEST: begin
                            if (in_range) begin
                                n_res.is_allocated = alloc_vec[pfa_pkg::IDX_W'(i_in.frame)];
                                n_res.ok = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.free_count = 6'(n_free);
                end
            end
            pfa_pkg::ST_SCAN: begin
                if (tok_end.active) begin
                    wr.owner   = r_owner;
                    wr.vpn     = r_vpn;
                    wr.wr_info = 1'b1;
                    wr.set_alloc = 1'b1;
                    if (r_mode == pfa_pkg::MODE_FORCED) begin
                        wr.en  = 1'b1;
                        wr.idx = tok_end.best_idx;
                        if (!tok_end.v_alloc) begin
                            n_free = r_free - 1'b1;
                        end
                        n_res.result_frame = 5'(tok_end.best_idx);
                        n_res.ok           = 1'b1;
                        n_res.victim_owner = tok_end.v_owner;
                        n_res.victim_vpn   = 16'(tok_end.v_vpn);
                    end else if (tok_end.found) begin
                        wr.en  = 1'b1;
                        wr.idx = tok_end.free_idx;
                        n_free = r_free - 1'b1;
                        n_res.result_frame = 5'(tok_end.free_idx);
                        n_res.ok           = 1'b1;
                    end
                    n_res.free_count = 6'(n_free);
                    n_state = pfa_pkg::ST_RESULT;
                end
            end
            pfa_pkg::ST_RESULT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfa_pkg::ST_IDLE;
            r_stamp  <= '0;
            r_free   <= pfa_pkg::FREE_W'(pfa_pkg::NUM_FRAMES);
            r_launch <= '0;
        end else begin
            r_state  <= n_state;
            r_stamp  <= n_stamp;
            r_free   <= n_free;
            r_launch <= n_launch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_owner <= n_owner;
        r_vpn   <= n_vpn;
        r_res   <= n_res;
    end

    assign o_out.result_frame = r_res.result_frame;
    assign o_out.ok           = r_res.ok;
    assign o_out.is_allocated = r_res.is_allocated;
    assign o_out.free_count   = r_res.free_count;
    assign o_out.victim_owner = r_res.victim_owner;
    assign o_out.victim_vpn   = r_res.victim_vpn;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(pfa_pkg::NUM_FRAMES))
        else $error("free count above frame count");
    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_end.active |-> (r_state == pfa_pkg::ST_SCAN))
        else $error("search token outside scan");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("request accepted while result pending");
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_end.active |=> (r_state == pfa_pkg::ST_RESULT))
        else $error("scan did not complete");

endmodule
